>>> src/hmcs_pkg.sv
// Types, constants and helpers shared by the height map contrast stretch unit.
`default_nettype none
package hmcs_pkg;

    // Width of one elevation sample.
    localparam int SAMPLE_WIDTH = 16;

    // Full-scale gray level and frame dimension limits.
    localparam logic [7:0] GRAY_FULL = 8'd255;
    localparam logic [7:0] DIM_MAX   = 8'd128;
    localparam logic [7:0] DIM_MIN   = 8'd1;
    localparam logic [7:0] DIM_RESET = 8'd100;

    // Configuration register indexes.
    localparam logic [7:0] CFG_NUM_ROWS    = 8'd0;
    localparam logic [7:0] CFG_NUM_COLUMNS = 8'd1;

    // Input item function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // Quotient bits produced by the serial divider, one per cycle.
    localparam int DIV_STEPS  = 8;
    localparam int STEP_WIDTH = 3;
    localparam logic [STEP_WIDTH-1:0] STEP_FIRST = 3'd7;
    localparam logic [STEP_WIDTH-1:0] STEP_LAST  = 3'd0;

    typedef struct packed {
        logic                           func;
        logic signed [SAMPLE_WIDTH-1:0] height;
    } in_t;

    typedef struct packed {
        logic [7:0]                     gray;
        logic                           pixel_valid;
        logic                           pixel_last;
        logic signed [SAMPLE_WIDTH-1:0] max_value;
        logic signed [SAMPLE_WIDTH-1:0] min_value;
        logic [6:0]                     max_row;
        logic [6:0]                     max_col;
        logic [6:0]                     min_row;
        logic [6:0]                     min_col;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  load_en;
        logic                  fetch_en;
        logic                  prep_en;
        logic                  div_en;
        logic [STEP_WIDTH-1:0] div_step;
        logic                  out_load;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_func;
        logic frame_full;
        logic out_free;
    } stat_t;

    // A dimension of zero counts as one, anything above the limit as the limit.
    function automatic logic [7:0] clamp_dim(input logic [7:0] d);
        logic [7:0] r;
        if (d == 8'd0) begin
            r = DIM_MIN;
        end else if (d > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/hmcs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module hmcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/hmcs_datapath.sv
// Datapath: frame store, running statistics, serial divider and output register.
`default_nettype none
module hmcs_datapath #(
    parameter int MAX_PIXELS = 16384
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr,
    input  wire logic [7:0]     cfg_index,
    input  wire logic [7:0]     cfg_data,
    input  wire hmcs_pkg::in_t  s_data,
    input  wire hmcs_pkg::ctrl_t ctrl,
    output hmcs_pkg::stat_t     stat,
    input  wire logic           m_ready,
    output logic                m_valid,
    output hmcs_pkg::out_t      m_data
);

    localparam int SW     = hmcs_pkg::SAMPLE_WIDTH;
    localparam int ADDR_W = $clog2(MAX_PIXELS > 1 ? MAX_PIXELS : 2);
    localparam int CNT_W  = ($clog2(MAX_PIXELS + 1) > 16) ? $clog2(MAX_PIXELS + 1) : 16;
    localparam int DIVD_W = SW + 8;

    // Configuration registers.
    logic [7:0] rows_reg, cols_reg;

    // Frame sequencing and statistics.
    logic [CNT_W-1:0]    load_index_reg, read_index_reg;
    logic [6:0]          load_row_reg;
    logic [7:0]          load_col_reg;
    logic                frame_full_reg;
    logic signed [SW-1:0] max_reg, min_reg;
    logic [6:0]          max_row_reg, max_col_reg, min_row_reg, min_col_reg;

    // Fetch working registers.
    logic                fetch_full_reg, fetch_last_reg, span_zero_reg;
    logic [DIVD_W-1:0]   rem_reg;
    logic [SW-1:0]       span_reg;
    logic [7:0]          quot_reg;

    // Output register.
    logic                out_valid_reg;
    hmcs_pkg::out_t      out_data_reg;

    logic [7:0]          rows_cl, cols_cl;
    logic [15:0]         dim_prod;
    logic [CNT_W-1:0]    frame_len;
    logic                ld_restart, ld_first, ld_done, col_wrap;
    logic [CNT_W-1:0]    ld_idx, ld_idx_inc;
    logic [6:0]          ld_row;
    logic [7:0]          ld_col;
    logic [CNT_W-1:0]    rd_idx, rd_idx_inc;
    logic                rd_last;
    logic [SW-1:0]       rd_data;
    logic [SW-1:0]       num_wide, span_wide;
    logic [DIVD_W-1:0]   dividend, div_sub;
    logic                div_ge;
    logic signed [SW-1:0] sample;

    // Frame length from the clamped dimensions, cut to the store depth.
    always_comb begin
        rows_cl  = hmcs_pkg::clamp_dim(rows_reg);
        cols_cl  = hmcs_pkg::clamp_dim(cols_reg);
        dim_prod = 16'(rows_cl) * 16'(cols_cl);
        if (CNT_W'(dim_prod) > CNT_W'(MAX_PIXELS)) begin
            frame_len = CNT_W'(MAX_PIXELS);
        end else begin
            frame_len = CNT_W'(dim_prod);
        end
    end

    // Load address: a load into a full frame starts a new one.
    always_comb begin
        sample     = s_data.height;
        ld_restart = frame_full_reg || (load_index_reg >= frame_len);
        ld_idx     = ld_restart ? '0 : load_index_reg;
        ld_row     = ld_restart ? '0 : load_row_reg;
        ld_col     = ld_restart ? '0 : load_col_reg;
        ld_first   = (ld_idx == '0);
        ld_idx_inc = ld_idx + CNT_W'(1);
        ld_done    = (ld_idx_inc >= frame_len);
        col_wrap   = ((ld_col + 8'd1) == cols_cl);
    end

    // Readout address: wraps to the first pixel after the last one.
    always_comb begin
        rd_idx     = (read_index_reg >= frame_len) ? '0 : read_index_reg;
        rd_idx_inc = rd_idx + CNT_W'(1);
        rd_last    = (rd_idx_inc >= frame_len);
    end

    hmcs_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_PIXELS)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (ctrl.load_en),
        .waddr (ld_idx[ADDR_W-1:0]),
        .wdata (sample),
        .raddr (rd_idx[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    // Offset and span are never negative, so their low bits hold the whole value.
    always_comb begin
        num_wide  = $unsigned(rd_data) - $unsigned(min_reg);
        span_wide = $unsigned(max_reg) - $unsigned(min_reg);
        dividend  = {num_wide, 8'd0} - {8'd0, num_wide};
    end

    // One restoring division step against the span shifted to the current bit.
    always_comb begin
        div_sub = DIVD_W'(span_reg) << ctrl.div_step;
        div_ge  = (rem_reg >= div_sub);
    end

    // Configuration, frame sequencing and running statistics.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg       <= hmcs_pkg::DIM_RESET;
            cols_reg       <= hmcs_pkg::DIM_RESET;
            load_index_reg <= '0;
            read_index_reg <= '0;
            load_row_reg   <= '0;
            load_col_reg   <= '0;
            frame_full_reg <= 1'b0;
            max_reg        <= '0;
            min_reg        <= '0;
            max_row_reg    <= '0;
            max_col_reg    <= '0;
            min_row_reg    <= '0;
            min_col_reg    <= '0;
        end else if (cfg_wr && (cfg_index == hmcs_pkg::CFG_NUM_ROWS ||
                                cfg_index == hmcs_pkg::CFG_NUM_COLUMNS)) begin
            if (cfg_index == hmcs_pkg::CFG_NUM_ROWS) begin
                rows_reg <= cfg_data;
            end else begin
                cols_reg <= cfg_data;
            end
            load_index_reg <= '0;
            read_index_reg <= '0;
            load_row_reg   <= '0;
            load_col_reg   <= '0;
            frame_full_reg <= 1'b0;
        end else if (ctrl.load_en) begin
            if (ld_first || sample > max_reg) begin
                max_reg     <= sample;
                max_row_reg <= ld_row;
                max_col_reg <= ld_col[6:0];
            end
            if (ld_first || sample < min_reg) begin
                min_reg     <= sample;
                min_row_reg <= ld_row;
                min_col_reg <= ld_col[6:0];
            end
            load_index_reg <= ld_idx_inc;
            if (col_wrap) begin
                load_col_reg <= '0;
                load_row_reg <= ld_row + 7'd1;
            end else begin
                load_col_reg <= ld_col + 8'd1;
                load_row_reg <= ld_row;
            end
            frame_full_reg <= ld_done;
            if (ld_restart || ld_done) begin
                read_index_reg <= '0;
            end
        end else if (ctrl.fetch_en && frame_full_reg) begin
            read_index_reg <= rd_last ? '0 : rd_idx_inc;
        end
    end

    // Fetch bookkeeping and the serial divider.
    always_ff @(posedge aclk) begin
        if (ctrl.fetch_en) begin
            fetch_full_reg <= frame_full_reg;
            fetch_last_reg <= frame_full_reg && rd_last;
        end
        if (ctrl.prep_en) begin
            rem_reg       <= dividend;
            span_reg      <= span_wide;
            span_zero_reg <= (span_wide == '0);
            quot_reg      <= '0;
        end else if (ctrl.div_en) begin
            if (div_ge) begin
                rem_reg                <= rem_reg - div_sub;
                quot_reg[ctrl.div_step] <= 1'b1;
            end
        end
    end

    // Output register: holds one result until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_data_reg.gray        <= (fetch_full_reg && !span_zero_reg) ? quot_reg : 8'd0;
            out_data_reg.pixel_valid <= fetch_full_reg;
            out_data_reg.pixel_last  <= fetch_last_reg;
            out_data_reg.max_value   <= max_reg;
            out_data_reg.min_value   <= min_reg;
            out_data_reg.max_row     <= max_row_reg;
            out_data_reg.max_col     <= max_col_reg;
            out_data_reg.min_row     <= min_row_reg;
            out_data_reg.min_col     <= min_col_reg;
        end
    end

    always_comb begin
        stat.in_func    = s_data.func;
        stat.frame_full = frame_full_reg;
        stat.out_free   = !out_valid_reg || m_ready;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
`default_nettype wire

>>> src/hmcs_ctrl.sv
// Controller: sequences loads, fetches and the serial divide.
`default_nettype none
module hmcs_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire hmcs_pkg::stat_t stat,
    output hmcs_pkg::ctrl_t      ctrl
);

    hmcs_pkg::state_t state_reg, state_next;
    logic [hmcs_pkg::STEP_WIDTH-1:0] step_reg, step_next;

    // State and divide step registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hmcs_pkg::ST_IDLE;
            step_reg  <= hmcs_pkg::STEP_FIRST;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            hmcs_pkg::ST_IDLE: begin
                if (s_valid && stat.in_func == hmcs_pkg::FUNC_FETCH) begin
                    state_next = stat.frame_full ? hmcs_pkg::ST_PREP : hmcs_pkg::ST_FINISH;
                end
            end
            hmcs_pkg::ST_PREP: begin
                state_next = hmcs_pkg::ST_DIV;
                step_next  = hmcs_pkg::STEP_FIRST;
            end
            hmcs_pkg::ST_DIV: begin
                if (step_reg == hmcs_pkg::STEP_LAST) begin
                    state_next = hmcs_pkg::ST_FINISH;
                end else begin
                    step_next = step_reg - hmcs_pkg::STEP_WIDTH'(1);
                end
            end
            hmcs_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = hmcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hmcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready       = 1'b0;
        ctrl          = '0;
        ctrl.div_step = step_reg;
        case (state_reg)
            hmcs_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                ctrl.load_en  = s_valid && stat.in_func == hmcs_pkg::FUNC_LOAD;
                ctrl.fetch_en = s_valid && stat.in_func == hmcs_pkg::FUNC_FETCH;
            end
            hmcs_pkg::ST_PREP: begin
                ctrl.prep_en = 1'b1;
            end
            hmcs_pkg::ST_DIV: begin
                ctrl.div_en = 1'b1;
            end
            hmcs_pkg::ST_FINISH: begin
                ctrl.out_load = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/height_map_contrast_stretch_unit.sv
// Top level of the height map min-max contrast stretch unit.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    hmcs_pkg::in_t  (func, height)
//  m_       out        m_valid / m_ready    hmcs_pkg::out_t (gray, flags, statistics)
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data (num_rows, num_columns)
//
// A load leaves s_ready high, so the next item may follow at once. A fetch on a full
// frame holds s_ready low after its transfer until its result is written: the store
// read happens at the transfer edge, then ST_PREP forms the dividend, ST_DIV runs the
// restoring divider from the top quotient bit down, and ST_FINISH writes the output
// register. A fetch on an incomplete frame skips the divide. A full output register
// stalls only a finished fetch; loads continue while a result waits.
// Reset is synchronous; the frame store is not cleared and needs no clearing pass.
`default_nettype none
module height_map_contrast_stretch_unit #(
    parameter int MAX_PIXELS = 16384
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire hmcs_pkg::in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output hmcs_pkg::out_t     m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [7:0]    cfg_data
);

    hmcs_pkg::ctrl_t ctrl;
    hmcs_pkg::stat_t stat;

    // Register writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    hmcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    hmcs_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    // A fetch transfer closes the input until its result is written.
    a_fetch_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.func == hmcs_pkg::FUNC_FETCH) |=> !s_ready)
        else $error("input accepted while a fetch is in progress");

    // The last pixel of a readout is always a valid pixel.
    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.pixel_last) |-> m_data.pixel_valid)
        else $error("pixel_last set on an invalid pixel");

    // A result from an incomplete frame carries gray zero.
    a_invalid_gray: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.pixel_valid) |-> (m_data.gray == 8'd0))
        else $error("nonzero gray on an invalid pixel");

    // The reported minimum never exceeds the reported maximum.
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_data.min_value) <= $signed(m_data.max_value)))
        else $error("minimum above maximum");

endmodule
`default_nettype wire

>>> dv/tb_height_map_contrast_stretch_unit.sv
// Self-checking testbench for the height map contrast stretch unit, with a built-in predictor.
`timescale 1ns / 100ps
module tb_height_map_contrast_stretch_unit;

    localparam int FRAME_CAP      = 16384;
    localparam int IDLE_PCT       = 19;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 700;
    localparam int BIG_COLS       = 3;
    localparam int BIG_PIXELS     = 128 * BIG_COLS;
    localparam int BIG_MIN_AT     = 127 * BIG_COLS + 1;

    // Register index that the block does not decode.
    localparam logic [7:0] CFG_UNUSED = 8'd2;

    // How the heights of one stimulus sequence are drawn.
    typedef enum int {
        HT_SPREAD,
        HT_CLUSTER,
        HT_EXTREME,
        HT_FLAT
    } height_style_t;

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    hmcs_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    hmcs_pkg::out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;
    logic steady    = 1'b0;

    // Stimulus and expectation stores.
    hmcs_pkg::in_t  pending_items[$];
    hmcs_pkg::out_t expected_pixels[$];
    int unsigned queued_items   = 0;
    int unsigned accepted_items = 0;

    // Predictor state: registers, frame store, indexes and running statistics.
    logic [7:0]         rows_reg   = hmcs_pkg::DIM_RESET;
    logic [7:0]         cols_reg   = hmcs_pkg::DIM_RESET;
    logic signed [15:0] frame_mem [0:FRAME_CAP-1];
    int unsigned        load_pos   = 0;
    int unsigned        read_pos   = 0;
    bit                 frame_done = 1'b0;
    logic signed [15:0] peak_val   = '0;
    logic signed [15:0] floor_val  = '0;
    logic [6:0]         peak_row   = '0;
    logic [6:0]         peak_col   = '0;
    logic [6:0]         floor_row  = '0;
    logic [6:0]         floor_col  = '0;

    // Run statistics.
    int unsigned n_loads     = 0;
    int unsigned n_fetches   = 0;
    int unsigned n_checked   = 0;
    int unsigned n_cfg       = 0;
    int unsigned n_frames    = 0;
    int unsigned mismatches  = 0;
    int unsigned quiet_cycles = 0;

    height_map_contrast_stretch_unit #(
        .MAX_PIXELS(FRAME_CAP)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always #1 aclk = ~aclk;

    // Effective frame dimension: zero counts as one, anything above the limit as the limit.
    function automatic int unsigned dim_eff(input logic [7:0] d);
        if (d == 8'd0) begin
            return 1;
        end
        return (d > hmcs_pkg::DIM_MAX) ? int'(hmcs_pkg::DIM_MAX) : int'(d);
    endfunction

    function automatic int unsigned frame_len();
        int unsigned n;
        n = dim_eff(rows_reg) * dim_eff(cols_reg);
        return (n > FRAME_CAP) ? FRAME_CAP : n;
    endfunction

    // Any decoded register write aborts the frame and the readout.
    function automatic void apply_reg(input logic [7:0] idx, input logic [7:0] val);
        n_cfg++;
        case (idx)
            hmcs_pkg::CFG_NUM_ROWS:    rows_reg = val;
            hmcs_pkg::CFG_NUM_COLUMNS: cols_reg = val;
            default:                   return;
        endcase
        load_pos   = 0;
        read_pos   = 0;
        frame_done = 1'b0;
    endfunction

    // Advance the predicted state by one accepted item; a fetch yields one expected result.
    function automatic void stretch_step(input hmcs_pkg::in_t item);
        int unsigned    len;
        int unsigned    cols;
        int unsigned    idx;
        int             span;
        int             num;
        hmcs_pkg::out_t res;
        len  = frame_len();
        cols = dim_eff(cols_reg);
        if (item.func == hmcs_pkg::FUNC_LOAD) begin
            n_loads++;
            // A load into a full frame starts the next frame.
            if (frame_done || load_pos >= len) begin
                load_pos   = 0;
                read_pos   = 0;
                frame_done = 1'b0;
            end
            frame_mem[load_pos] = item.height;
            // The first sample sets both extremes; ties keep the earlier position.
            if (load_pos == 0 || item.height > peak_val) begin
                peak_val = item.height;
                peak_row = 7'(load_pos / cols);
                peak_col = 7'(load_pos % cols);
            end
            if (load_pos == 0 || item.height < floor_val) begin
                floor_val = item.height;
                floor_row = 7'(load_pos / cols);
                floor_col = 7'(load_pos % cols);
            end
            load_pos++;
            if (load_pos >= len) begin
                frame_done = 1'b1;
                read_pos   = 0;
                n_frames++;
            end
        end else begin
            n_fetches++;
            res = '0;
            if (frame_done) begin
                idx  = (read_pos >= len) ? 0 : read_pos;
                span = int'(peak_val) - int'(floor_val);
                num  = int'(frame_mem[idx]) - int'(floor_val);
                res.gray        = (span == 0) ? 8'd0 :
                                  8'((num * int'(hmcs_pkg::GRAY_FULL)) / span);
                res.pixel_valid = 1'b1;
                // The readout wraps to the first pixel after the last one.
                if (idx + 1 >= len) begin
                    res.pixel_last = 1'b1;
                    read_pos       = 0;
                end else begin
                    read_pos = idx + 1;
                end
            end
            res.max_value = peak_val;
            res.min_value = floor_val;
            res.max_row   = peak_row;
            res.max_col   = peak_col;
            res.min_row   = floor_row;
            res.min_col   = floor_col;
            expected_pixels.insert(expected_pixels.size(), res);
        end
    endfunction

    function automatic void check_field(input string name, input integer want,
                                        input integer got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Input driver: presents queued items, idling at random unless a steady stretch is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                stretch_step(s_data);
                accepted_items++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each transfer with the oldest expected pixel.
    always @(posedge aclk) begin
        hmcs_pkg::out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %h", $time, m_data);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    n_checked++;
                    check_field("gray", want.gray, m_data.gray);
                    check_field("pixel_valid", want.pixel_valid, m_data.pixel_valid);
                    check_field("pixel_last", want.pixel_last, m_data.pixel_last);
                    check_field("max_value", want.max_value, m_data.max_value);
                    check_field("min_value", want.min_value, m_data.min_value);
                    check_field("max_row", want.max_row, m_data.max_row);
                    check_field("max_col", want.max_col, m_data.max_col);
                    check_field("min_row", want.min_row, m_data.min_row);
                    check_field("min_col", want.min_col, m_data.min_col);
                end
            end
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_pixels.size());
            $display("tb_height_map_contrast_stretch_unit: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_load(input logic signed [15:0] h);
        hmcs_pkg::in_t item;
        item.func   = hmcs_pkg::FUNC_LOAD;
        item.height = h;
        pending_items.insert(pending_items.size(), item);
        queued_items++;
    endtask

    // The height of a fetch is ignored, so it carries random bits.
    task automatic push_fetch();
        hmcs_pkg::in_t item;
        item.func   = hmcs_pkg::FUNC_FETCH;
        item.height = 16'($urandom);
        pending_items.insert(pending_items.size(), item);
        queued_items++;
    endtask

    // Wait until every item is in and every result is out, then let the block settle.
    task automatic drain();
        while (accepted_items != queued_items || expected_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write transfer; called only at a clock edge while the block is idle.
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] pick_height(input height_style_t style,
                                                       input logic signed [15:0] base);
        case (style)
            HT_SPREAD:  return 16'($urandom);
            HT_CLUSTER: return base + 16'($urandom_range(0, 3));
            HT_EXTREME: begin
                case ($urandom_range(4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return -16'sd1;
                    3:       return 16'sd0;
                    default: return 16'sd1;
                endcase
            end
            default:    return base;
        endcase
    endfunction

    // Mostly small dimensions; the wide pick covers the clamp and the out-of-range values.
    function automatic logic [7:0] pick_dim(input bit wide);
        if (!wide) begin
            return ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
        end
        case ($urandom_range(2))
            0:       return hmcs_pkg::DIM_MAX;
            1:       return 8'hFF;
            default: return 8'($urandom_range(129, 254));
        endcase
    endfunction

    // Stimulus: directed cases, random phases, then one tall frame without idling.
    initial begin
        int unsigned   len;
        int unsigned   nf;
        int unsigned   cnt;
        int unsigned   phase;
        int unsigned   random_start;
        int unsigned   kind;
        logic [7:0]    r;
        logic [7:0]    c;
        height_style_t style;
        logic signed [15:0] base;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fetch with nothing loaded: all statistics read as zero.
        push_fetch();
        drain();

        // Zero dimensions give a one-pixel frame: flat, wrapping, reload of a full frame.
        write_reg(hmcs_pkg::CFG_NUM_ROWS, 8'd0);
        write_reg(hmcs_pkg::CFG_NUM_COLUMNS, 8'd0);
        push_load(16'sh7FFF);
        push_fetch();
        push_fetch();
        push_load(16'sh8000);
        push_fetch();
        drain();

        // Two by three frame: early fetch, ties on both extremes, full readout with wrap.
        write_reg(hmcs_pkg::CFG_NUM_ROWS, 8'd2);
        write_reg(hmcs_pkg::CFG_NUM_COLUMNS, 8'd3);
        push_load(16'sh8000);
        push_load(16'sd5);
        push_fetch();
        push_load(16'sh7FFF);
        push_load(16'sh7FFF);
        push_load(16'sh8000);
        push_load(16'sd0);
        repeat (7) push_fetch();
        drain();

        // Random phases: mostly whole frames with their readout, some aborted or noisy.
        random_start = queued_items;
        for (phase = 0; queued_items - random_start < RANDOM_ITEMS; phase++) begin
            steady <= (phase % 12 == 6);
            if (phase == 0 || $urandom_range(99) < 70) begin
                r = pick_dim(1'b0);
                c = pick_dim(1'b0);
                if ($urandom_range(9) == 0) begin
                    if ($urandom_range(1) == 1) begin
                        r = pick_dim(1'b1);
                        c = 8'($urandom_range(0, 2));
                    end else begin
                        c = pick_dim(1'b1);
                        r = 8'($urandom_range(0, 2));
                    end
                end
                case ($urandom_range(9))
                    0:       write_reg(hmcs_pkg::CFG_NUM_ROWS, r);
                    1:       write_reg(hmcs_pkg::CFG_NUM_COLUMNS, c);
                    default: begin
                        write_reg(hmcs_pkg::CFG_NUM_ROWS, r);
                        write_reg(hmcs_pkg::CFG_NUM_COLUMNS, c);
                    end
                endcase
                if ($urandom_range(19) == 0) begin
                    write_reg(CFG_UNUSED, 8'($urandom));
                end
            end
            len   = frame_len();
            kind  = $urandom_range(99);
            style = height_style_t'($urandom_range(3));
            base  = 16'($urandom);
            if (kind < 75) begin
                for (cnt = 0; cnt < len; cnt++) begin
                    if ($urandom_range(9) == 0) begin
                        push_fetch();
                    end
                    push_load(pick_height(style, base));
                end
                nf = (len > 16) ? len + $urandom_range(0, 2) : $urandom_range(1, 2 * len + 1);
                repeat (nf) push_fetch();
            end else if (kind < 90) begin
                // Partial frame, left for the next phase to finish or abort.
                repeat ($urandom_range(0, len - 1)) begin
                    if ($urandom_range(3) == 0) begin
                        push_fetch();
                    end
                    push_load(pick_height(style, base));
                end
                repeat ($urandom_range(1, 2)) push_fetch();
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    if ($urandom_range(1) == 1) begin
                        push_fetch();
                    end else begin
                        push_load(pick_height(style, base));
                    end
                end
            end
            drain();
        end

        // Tall frame without idling: rows above the limit, extremes in the last row.
        steady <= 1'b1;
        write_reg(hmcs_pkg::CFG_NUM_ROWS, 8'hFF);
        write_reg(hmcs_pkg::CFG_NUM_COLUMNS, 8'(BIG_COLS));
        for (cnt = 0; cnt < BIG_PIXELS; cnt++) begin
            if (cnt == BIG_MIN_AT) begin
                push_load(16'sh8000);
            end else if (cnt == BIG_PIXELS - 1) begin
                push_load(16'sh7FFF);
            end else begin
                push_load(16'($urandom_range(0, 2000) - 1000));
            end
        end
        repeat (BIG_PIXELS + 2) push_fetch();
        drain();

        $display("Run covered %0d loads and %0d fetches, %0d register writes, %0d full frames.",
                 n_loads, n_fetches, n_cfg, n_frames);
        $display("Results compared: %0d, field mismatches and stray results: %0d.",
                 n_checked, mismatches);
        if (mismatches == 0) begin
            $display("tb_height_map_contrast_stretch_unit: PASS");
        end else begin
            $display("tb_height_map_contrast_stretch_unit: FAIL");
        end
        $finish;
    end

endmodule
